// ===== hdl/lant_pkg.sv =====
// ----------------------------------------------------------------------------
// lant_pkg: shared types and constants for the Langton's ant grid stepper
// Request and result beat types, register map codes and heading codes.
// ----------------------------------------------------------------------------
package lant_pkg;

    // Default grid bounds.
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Register values after reset.
    localparam int          SIZE_RST    = 64;
    localparam logic [1:0]  HEADING_RST = 2'd2;

    // Register map: word index on the configuration port.
    localparam logic [1:0] REG_ROWS    = 2'd0;
    localparam logic [1:0] REG_COLS    = 2'd1;
    localparam logic [1:0] REG_HEADING = 2'd2;

    // Request kinds.
    localparam logic REQ_STEP = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Heading codes and the move that each one makes.
    localparam logic [1:0] HEAD_COL_INC = 2'd0;
    localparam logic [1:0] HEAD_ROW_DEC = 2'd1;
    localparam logic [1:0] HEAD_COL_DEC = 2'd2;
    localparam logic [1:0] HEAD_ROW_INC = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [5:0] read_row;
        logic [5:0] read_col;
    } req_t;

    typedef struct packed {
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       cell_value;
        logic [5:0] ant_row;
        logic [5:0] ant_col;
        logic [1:0] heading;
    } rsp_t;

endpackage

// ===== hdl/langtons_ant_grid_step.sv =====
// ----------------------------------------------------------------------------
// langtons_ant_grid_step: Langton's ant on a toroidal one-bit grid
// Steps the ant or reads a grid cell; the grid lives in a one-bit RAM.
//
//   Channel   Handshake              Payload          Direction
//   request   start / busy           req   (req_t)    in
//   result    done (one-cycle beat)  result (rsp_t)   out
//   config    APB psel/penable       pwdata, prdata   in / out
//
// Every request does the RAM read in the accept cycle, then the
// read-modify-write and result in the next; busy is high during that cycle.
// The result beat appears in the cycle after that and cannot be held off.
// After reset the block clears the grid, one cell per cycle, all
// MAX_ROWS * 2**clog2(MAX_COLS) cells, with busy high.
// Config writes are taken in every cycle; register writes re-center the ant.
// ----------------------------------------------------------------------------
module langtons_ant_grid_step #(
    parameter int MAX_ROWS = lant_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lant_pkg::MAX_COLS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  lant_pkg::req_t  req,
    output logic            done,
    output lant_pkg::rsp_t  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int AW     = RW + CW;
    localparam int DEPTH  = MAX_ROWS * (1 << CW);
    // One bit above the widest of the read field and the index, so that the
    // grid bound itself fits in the compare.
    localparam int RXW    = ((RW > 6) ? RW : 6) + 1;
    localparam int CXW    = ((CW > 6) ? CW : 6) + 1;
    localparam int NRW    = ((RW > 7) ? RW : 7) + 1;
    localparam int NCW    = ((CW > 7) ? CW : 7) + 1;
    localparam int RowCap = (MAX_ROWS < 127) ? MAX_ROWS : 127;
    localparam int ColCap = (MAX_COLS < 127) ? MAX_COLS : 127;
    localparam int RowRst = (lant_pkg::SIZE_RST < RowCap) ? lant_pkg::SIZE_RST : RowCap;
    localparam int ColRst = (lant_pkg::SIZE_RST < ColCap) ? lant_pkg::SIZE_RST : ColCap;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } state_t;

    state_t          state_reg,    state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [6:0]      rows_reg,     rows_next;
    logic [6:0]      cols_reg,     cols_next;
    logic [1:0]      shead_reg,    shead_next;
    logic [RW-1:0]   pos_row_reg,  pos_row_next;
    logic [CW-1:0]   pos_col_reg,  pos_col_next;
    logic [1:0]      dir_reg,      dir_next;
    logic            done_reg,     done_next;
    logic            op_reg,       op_next;
    logic [5:0]      rd_row_reg,   rd_row_next;
    logic [5:0]      rd_col_reg,   rd_col_next;
    logic            oob_reg,      oob_next;
    lant_pkg::rsp_t  result_reg,   result_next;

    logic            accept;
    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    logic [6:0]      cfg_val;
    logic [RXW-1:0]  rr_ext;
    logic [CXW-1:0]  rc_ext;
    logic            rd_oob;
    logic [AW-1:0]   ant_addr;
    logic [AW-1:0]   rd_addr;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [0:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [0:0]      ram_rdata;
    logic            was_set;
    logic [1:0]      move_dir;
    logic [NRW-1:0]  row_plus;
    logic [NCW-1:0]  col_plus;
    logic [RW-1:0]   row_inc;
    logic [RW-1:0]   row_dec;
    logic [CW-1:0]   col_inc;
    logic [CW-1:0]   col_dec;
    logic [RW-1:0]   step_row;
    logic [CW-1:0]   step_col;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;
    assign pready  = 1'b1;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    assign cfg_val = pwdata[6:0];

    always_comb
    begin
        case (cfg_idx)
            lant_pkg::REG_ROWS:    prdata = 32'(rows_reg);
            lant_pkg::REG_COLS:    prdata = 32'(cols_reg);
            lant_pkg::REG_HEADING: prdata = 32'(shead_reg);
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        shead_next = shead_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                lant_pkg::REG_ROWS:
                begin
                    if (cfg_val == 7'd0)
                        rows_next = 7'd1;
                    else if (cfg_val > 7'(RowCap))
                        rows_next = 7'(RowCap);
                    else
                        rows_next = cfg_val;
                end
                lant_pkg::REG_COLS:
                begin
                    if (cfg_val == 7'd0)
                        cols_next = 7'd1;
                    else if (cfg_val > 7'(ColCap))
                        cols_next = 7'(ColCap);
                    else
                        cols_next = cfg_val;
                end
                lant_pkg::REG_HEADING: shead_next = pwdata[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Addresses and grid RAM
    // ------------------------------------------------------------------
    assign rr_ext   = RXW'(req.read_row);
    assign rc_ext   = CXW'(req.read_col);
    assign rd_oob   = (rr_ext >= RXW'(MAX_ROWS)) || (rc_ext >= CXW'(MAX_COLS));
    assign ant_addr = {pos_row_reg, pos_col_reg};
    assign rd_addr  = {rr_ext[RW-1:0], rc_ext[CW-1:0]};

    assign ram_raddr = (req.req_type == lant_pkg::REQ_READ) ? rd_addr : ant_addr;
    assign ram_we    = (state_reg == ST_CLEAR) ||
                       ((state_reg == ST_ACCESS) && (op_reg == lant_pkg::REQ_STEP));
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : ant_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 1'b0 : ~ram_rdata;

    lant_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Ant move
    // ------------------------------------------------------------------
    assign was_set  = ram_rdata[0];
    // A set cell sends the ant the opposite way.
    assign move_dir = dir_reg ^ {was_set, 1'b0};
    assign row_plus = NRW'(pos_row_reg) + NRW'(1);
    assign col_plus = NCW'(pos_col_reg) + NCW'(1);
    assign row_inc  = (row_plus >= NRW'(rows_reg)) ? '0 : RW'(row_plus);
    assign col_inc  = (col_plus >= NCW'(cols_reg)) ? '0 : CW'(col_plus);
    assign row_dec  = (pos_row_reg == '0) ? RW'(rows_reg - 7'd1) : pos_row_reg - RW'(1);
    assign col_dec  = (pos_col_reg == '0) ? CW'(cols_reg - 7'd1) : pos_col_reg - CW'(1);

    always_comb
    begin
        step_row = pos_row_reg;
        step_col = pos_col_reg;
        case (move_dir)
            lant_pkg::HEAD_COL_INC: step_col = col_inc;
            lant_pkg::HEAD_ROW_DEC: step_row = row_dec;
            lant_pkg::HEAD_COL_DEC: step_col = col_dec;
            lant_pkg::HEAD_ROW_INC: step_row = row_inc;
            default:                step_row = pos_row_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pos_row_next  = pos_row_reg;
        pos_col_next  = pos_col_reg;
        dir_next      = dir_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        rd_row_next   = rd_row_reg;
        rd_col_next   = rd_col_reg;
        oob_next      = oob_reg;
        result_next   = result_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_ACCESS;
                    op_next     = req.req_type;
                    rd_row_next = req.read_row;
                    rd_col_next = req.read_col;
                    oob_next    = rd_oob;
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (op_reg == lant_pkg::REQ_STEP)
                begin
                    pos_row_next = step_row;
                    pos_col_next = step_col;
                    dir_next     = was_set ? dir_reg + 2'd1 : dir_reg - 2'd1;
                    result_next.cell_row   = 6'(pos_row_reg);
                    result_next.cell_col   = 6'(pos_col_reg);
                    result_next.cell_value = ~was_set;
                end
                else
                begin
                    result_next.cell_row   = rd_row_reg;
                    result_next.cell_col   = rd_col_reg;
                    result_next.cell_value = was_set && !oob_reg;
                end
                result_next.ant_row = 6'(pos_row_next);
                result_next.ant_col = 6'(pos_col_next);
                result_next.heading = dir_next;
            end
            default: state_next = ST_IDLE;
        endcase

        // A register write re-centers the ant with the start heading.
        if (cfg_wr && (cfg_idx == lant_pkg::REG_ROWS || cfg_idx == lant_pkg::REG_COLS ||
                       cfg_idx == lant_pkg::REG_HEADING))
        begin
            pos_row_next = RW'(rows_next >> 1);
            pos_col_next = CW'(cols_next >> 1);
            dir_next     = shead_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rows_reg     <= 7'(RowRst);
            cols_reg     <= 7'(ColRst);
            shead_reg    <= lant_pkg::HEADING_RST;
            pos_row_reg  <= RW'(RowRst / 2);
            pos_col_reg  <= CW'(ColRst / 2);
            dir_reg      <= lant_pkg::HEADING_RST;
            done_reg     <= 1'b0;
            op_reg       <= lant_pkg::REQ_STEP;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            shead_reg    <= shead_next;
            pos_row_reg  <= pos_row_next;
            pos_col_reg  <= pos_col_next;
            dir_reg      <= dir_next;
            done_reg     <= done_next;
            op_reg       <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= rd_row_next;
        rd_col_reg <= rd_col_next;
        oob_reg    <= oob_next;
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done_reg)
        else $error("accepted request did not produce a result beat two cycles later");

    a_done_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_ACCESS))
        else $error("result beat without a preceding access cycle");

    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && accept))
        else $error("grid write collides with a new request read");

    a_ant_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (NRW'(pos_row_reg) < NRW'(rows_reg)) && (NCW'(pos_col_reg) < NCW'(cols_reg)))
        else $error("ant position outside the grid in use");

endmodule

// ===== hdl/lant_ram.sv =====
// ----------------------------------------------------------------------------
// lant_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lant_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== verif/langtons_ant_grid_step_tb.sv =====
// ----------------------------------------------------------------------------
// langtons_ant_grid_step_tb: self-checking bench for the Langton's ant stepper
// Drives step and cell-read beats through start/busy and predicts every
// result beat from a private copy of the grid, the ant and the size registers.
// The register port re-centers the ant between phases: directed corner cases
// first, then randomly sized grids, mostly steps, random gaps but one gap-free phase.
// ----------------------------------------------------------------------------
module langtons_ant_grid_step_tb;

    localparam int         GRID_ROWS       = lant_pkg::MAX_ROWS_DEF;
    localparam int         GRID_COLS       = lant_pkg::MAX_COLS_DEF;
    localparam logic [1:0] REG_UNUSED      = 2'd3;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         RANDOM_PHASES   = 12;
    localparam int         ITEMS_PER_PHASE = 77;

    logic            clk     = 1'b0;
    logic            rst_n   = 1'b0;
    logic            start   = 1'b0;
    logic            busy;
    lant_pkg::req_t  req     = '0;
    logic            done;
    lant_pkg::rsp_t  result;
    logic            psel    = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite  = 1'b0;
    logic [3:0]      paddr   = '0;
    logic [31:0]     pwdata  = '0;
    logic [31:0]     prdata;
    logic            pready;

    // Predicted block state.
    bit          grid_model [GRID_ROWS][GRID_COLS];
    int          rows_n;
    int          cols_n;
    logic [1:0]  head_start;
    logic [5:0]  ant_r;
    logic [5:0]  ant_c;
    logic [1:0]  ant_h;

    lant_pkg::req_t  cmd_queue[$];
    lant_pkg::rsp_t  rsp_expected[$];
    bit          no_gaps = 1'b0;
    int          fails = 0;
    int          cycles = 0;
    int          n_steps = 0;
    int          n_set_hits = 0;
    int          n_reads = 0;
    int          n_beats = 0;
    int          n_settings = 0;

    langtons_ant_grid_step uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void ant_place();
        ant_r = 6'(rows_n / 2);
        ant_c = 6'(cols_n / 2);
        ant_h = head_start;
    endfunction

    function automatic int clamp_size(logic [6:0] v, int maxv);
        if (v == 7'd0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic void cfg_apply(logic [1:0] idx, logic [31:0] val);
        case (idx)
            lant_pkg::REG_ROWS:    rows_n = clamp_size(val[6:0], GRID_ROWS);
            lant_pkg::REG_COLS:    cols_n = clamp_size(val[6:0], GRID_COLS);
            lant_pkg::REG_HEADING: head_start = val[1:0];
            default:               return;
        endcase
        ant_place();
    endfunction

    function automatic lant_pkg::rsp_t ant_predict(lant_pkg::req_t r);
        lant_pkg::rsp_t o;
        bit             was_set;
        logic [1:0]     move;
        if (r.req_type == lant_pkg::REQ_STEP)
        begin
            was_set = grid_model[ant_r][ant_c];
            grid_model[ant_r][ant_c] = !was_set;
            o.cell_row   = ant_r;
            o.cell_col   = ant_c;
            o.cell_value = !was_set;
            // A set cell sends the ant the opposite way of its heading.
            move = was_set ? (ant_h ^ 2'd2) : ant_h;
            case (move)
                lant_pkg::HEAD_COL_INC:
                    ant_c = (int'(ant_c) + 1 >= cols_n) ? 6'd0 : ant_c + 6'd1;
                lant_pkg::HEAD_ROW_DEC:
                    ant_r = (ant_r == 6'd0) ? 6'(rows_n - 1) : ant_r - 6'd1;
                lant_pkg::HEAD_COL_DEC:
                    ant_c = (ant_c == 6'd0) ? 6'(cols_n - 1) : ant_c - 6'd1;
                default:
                    ant_r = (int'(ant_r) + 1 >= rows_n) ? 6'd0 : ant_r + 6'd1;
            endcase
            ant_h = was_set ? ant_h + 2'd1 : ant_h - 2'd1;
            n_steps++;
            if (was_set)
                n_set_hits++;
        end
        else
        begin
            o.cell_row   = r.read_row;
            o.cell_col   = r.read_col;
            o.cell_value = grid_model[r.read_row][r.read_col];
            n_reads++;
        end
        o.ant_row = ant_r;
        o.ant_col = ant_c;
        o.heading = ant_h;
        return o;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Driver: a beat is taken at an edge with start high and busy low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
                rsp_expected.push_back(ant_predict(req));
            if (start && busy)
            begin
                // Hold the pending beat until the block takes it.
            end
            else if (cmd_queue.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 10))
            begin
                start <= 1'b1;
                req   <= cmd_queue.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every done beat is matched against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        lant_pkg::rsp_t want;
        if (rst_n && done)
        begin
            n_beats++;
            if (rsp_expected.size() == 0)
            begin
                $error("result beat with nothing expected: %p", result);
                fails++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                check_field("cell_row", want.cell_row, result.cell_row);
                check_field("cell_col", want.cell_col, result.cell_col);
                check_field("cell_value", want.cell_value, result.cell_value);
                check_field("ant_row", want.ant_row, result.ant_row);
                check_field("ant_col", want.ant_col, result.ant_col);
                check_field("heading", want.heading, result.heading);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $error("timed out with %0d beats still expected", rsp_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_apply(idx, val);
    endtask

    task automatic queue_item(logic kind, int row, int col);
        lant_pkg::req_t r;
        r.req_type = kind;
        r.read_row = 6'(row);
        r.read_col = 6'(col);
        cmd_queue.push_back(r);
    endtask

    // Wait until every queued beat is taken and answered, then let the
    // block settle before the registers change.
    task automatic drain();
        while (cmd_queue.size() != 0 || start || rsp_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Grid sizes lean toward small grids so the ant keeps revisiting cells;
    // the register takes only the low seven bits, the rest is noise.
    function automatic logic [31:0] pick_size();
        logic [31:0] v;
        int          k;
        v = $urandom;
        k = $urandom_range(0, 9);
        case (k)
            0:       v[6:0] = 7'd0;
            1:       v[6:0] = 7'd64;
            2:       v[6:0] = 7'($urandom_range(65, 127));
            3, 4:    v[6:0] = 7'($urandom_range(1, 64));
            default: v[6:0] = 7'($urandom_range(1, 8));
        endcase
        return v;
    endfunction

    function automatic lant_pkg::req_t rand_item();
        lant_pkg::req_t r;
        r.read_row = 6'($urandom);
        r.read_col = 6'($urandom);
        r.req_type = ($urandom_range(0, 99) < 75) ? lant_pkg::REQ_STEP : lant_pkg::REQ_READ;
        if (r.req_type == lant_pkg::REQ_READ && $urandom_range(0, 1) == 1)
        begin
            r.read_row = 6'($urandom_range(0, rows_n - 1));
            r.read_col = 6'($urandom_range(0, cols_n - 1));
        end
        return r;
    endfunction

    initial
    begin : stimulus
        int          nw;
        logic [1:0]  idx;
        logic [31:0] val;
        foreach (grid_model[r, c])
            grid_model[r][c] = 1'b0;
        rows_n     = lant_pkg::SIZE_RST;
        cols_n     = lant_pkg::SIZE_RST;
        head_start = lant_pkg::HEADING_RST;
        ant_place();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // The block clears its grid after reset with busy high.
        do
            @(posedge clk);
        while (busy);

        // Reset settings: corners, a short walk from the center, then its trail.
        n_settings++;
        queue_item(lant_pkg::REQ_READ, 0, 0);
        queue_item(lant_pkg::REQ_READ, 63, 63);
        queue_item(lant_pkg::REQ_READ, 0, 63);
        repeat (6) queue_item(lant_pkg::REQ_STEP, 0, 0);
        queue_item(lant_pkg::REQ_READ, 32, 32);
        queue_item(lant_pkg::REQ_READ, 32, 31);
        drain();

        // Zero sizes become a single cell: every move wraps onto itself.
        n_settings++;
        reg_write(lant_pkg::REG_ROWS, 32'd0);
        reg_write(lant_pkg::REG_COLS, 32'hFFFF_FF80);
        reg_write(lant_pkg::REG_HEADING, {30'd0, lant_pkg::HEAD_COL_INC});
        repeat (4) queue_item(lant_pkg::REQ_STEP, 63, 63);
        queue_item(lant_pkg::REQ_READ, 0, 0);
        queue_item(lant_pkg::REQ_READ, 63, 63);
        queue_item(lant_pkg::REQ_READ, 32, 32);
        drain();

        // Oversized values saturate; a write past the register list is ignored.
        n_settings++;
        reg_write(lant_pkg::REG_ROWS, 32'd127);
        reg_write(lant_pkg::REG_COLS, 32'hFFFF_FFC8);
        reg_write(lant_pkg::REG_HEADING, {30'h3FFF_FFFF, lant_pkg::HEAD_ROW_INC});
        reg_write(REG_UNUSED, 32'h0000_0001);
        repeat (5) queue_item(lant_pkg::REQ_STEP, 0, 0);
        queue_item(lant_pkg::REQ_READ, 32, 32);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            n_settings++;
            nw = $urandom_range(1, 4);
            for (int w = 0; w < nw; w++)
            begin
                idx = 2'($urandom_range(0, 3));
                val = (idx == lant_pkg::REG_ROWS || idx == lant_pkg::REG_COLS) ?
                      pick_size() : $urandom;
                reg_write(idx, val);
            end
            no_gaps = (ph == RANDOM_PHASES / 2);
            repeat (ITEMS_PER_PHASE) cmd_queue.push_back(rand_item());
            drain();
        end
        no_gaps = 1'b0;

        if (rsp_expected.size() != 0)
        begin
            $error("%0d result beats never arrived", rsp_expected.size());
            fails++;
        end
        $display("Ran %0d steps (%0d onto set cells) and %0d cell reads under %0d settings.",
                 n_steps, n_set_hits, n_reads, n_settings);
        $display("Compared %0d result beats, %0d mismatches.", n_beats, fails);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
